### rtl/core/hfdx_pkg.sv
// Package for the header frame deframer with XOR checksum.
// Holds the parser phase type, header constants and the state and result structs.
// No dependencies.
package hfdx_pkg;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_N     = 3'd1,
      PH_E     = 3'd2,
      PH_R     = 3'd3,
      PH_LEN   = 3'd4,
      PH_TOKEN = 3'd5,
      PH_BODY  = 3'd6
   } phase_type;

   localparam logic       OP_BYTE       = 1'b0;
   localparam logic       OP_TICK       = 1'b1;

   localparam logic [7:0] HDR_U         = 8'h55;
   localparam logic [7:0] HDR_N         = 8'h4E;
   localparam logic [7:0] HDR_E         = 8'h45;
   localparam logic [7:0] HDR_R         = 8'h52;
   localparam logic [7:0] HDR_TOKEN     = 8'h3A;
   localparam logic [7:0] TIMEOUT_RESET = 8'd5;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] running_xor;
      logic [7:0] bytes_left;
      logic [7:0] timeout_left;
      logic [7:0] body_count;
   } state_type;

   typedef struct packed {
      logic       body_valid;
      logic [7:0] body_byte;
      logic [7:0] body_position;
      logic       frame_ok;
      logic       frame_bad;
      logic       timed_out;
   } result_type;

endpackage

### rtl/core/hfdx_parser.sv
// Single-step parser of the deframer: next parser state and result for one request.
// Purely combinational; uses hfdx_pkg.
module hfdx_parser (
   input  logic                  op,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            timeout_ticks,
   input  hfdx_pkg::state_type   cur,
   output hfdx_pkg::state_type   nxt,
   output hfdx_pkg::result_type  res
);

   logic [7:0] expected;
   logic [7:0] left_dec;
   logic       is_u;
   logic       expire;

   always_comb begin
      unique case (cur.phase)
         hfdx_pkg::PH_N: expected = hfdx_pkg::HDR_N;
         hfdx_pkg::PH_E: expected = hfdx_pkg::HDR_E;
         hfdx_pkg::PH_R: expected = hfdx_pkg::HDR_R;
         default:        expected = hfdx_pkg::HDR_TOKEN;
      endcase
   end

   assign left_dec = cur.bytes_left - 8'd1;
   assign is_u     = (rx_byte == hfdx_pkg::HDR_U);
   assign expire   = (cur.timeout_left == 8'd1);

   // next state
   always_comb begin
      nxt = cur;
      if (op == hfdx_pkg::OP_TICK) begin
         if (cur.timeout_left != 8'd0) begin
            nxt.timeout_left = cur.timeout_left - 8'd1;
            if (expire) begin
               nxt.phase = hfdx_pkg::PH_HUNT;
            end
         end
      end else begin
         unique case (cur.phase)
            hfdx_pkg::PH_HUNT: begin
               if (is_u) begin
                  nxt.phase        = hfdx_pkg::PH_N;
                  nxt.timeout_left = timeout_ticks;
                  nxt.running_xor  = rx_byte;
               end
            end
            hfdx_pkg::PH_N, hfdx_pkg::PH_E, hfdx_pkg::PH_R, hfdx_pkg::PH_TOKEN: begin
               if (rx_byte == expected) begin
                  nxt.running_xor = cur.running_xor ^ rx_byte;
                  nxt.phase       = hfdx_pkg::phase_type'(cur.phase + 3'd1);
               end else if (is_u) begin
                  nxt.phase        = hfdx_pkg::PH_N;
                  nxt.timeout_left = timeout_ticks;
                  nxt.running_xor  = rx_byte;
               end else begin
                  nxt.phase = hfdx_pkg::PH_HUNT;
               end
            end
            hfdx_pkg::PH_LEN: begin
               nxt.running_xor = cur.running_xor ^ rx_byte;
               nxt.bytes_left  = rx_byte;
               nxt.body_count  = 8'd0;
               nxt.phase       = hfdx_pkg::PH_TOKEN;
            end
            hfdx_pkg::PH_BODY: begin
               nxt.bytes_left = left_dec;
               if (left_dec != 8'd0) begin
                  nxt.running_xor = cur.running_xor ^ rx_byte;
                  nxt.body_count  = cur.body_count + 8'd1;
               end else begin
                  nxt.phase = hfdx_pkg::PH_HUNT;
               end
            end
            default: begin
               nxt.phase = hfdx_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // result
   always_comb begin
      res = '0;
      if (op == hfdx_pkg::OP_TICK) begin
         res.timed_out = expire;
      end else if (cur.phase == hfdx_pkg::PH_BODY) begin
         if (left_dec != 8'd0) begin
            res.body_valid    = 1'b1;
            res.body_byte     = rx_byte;
            res.body_position = cur.body_count;
         end else begin
            res.frame_ok  = (rx_byte == cur.running_xor);
            res.frame_bad = (rx_byte != cur.running_xor);
         end
      end
   end

endmodule

### rtl/core/header_frame_deframer_xor_core.sv
// A request is held in the input register; its result is held in the response register.
// Throughput: one request per cycle; the parser step is one pass between the
// input register and the response register, which stall together on rsp_tready.
// Reset: synchronous, active high; clears the pipeline valids and parser state
// and loads the timeout register with 5.
module header_frame_deframer_xor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] body_byte, [15:8] body_position
   output logic [3:0]  rsp_tuser,   // [0] body_valid, [1] frame_ok, [2] frame_bad, [3] timed_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // timeout_ticks
);

   logic                 in_valid_ff;
   logic                 op_ff;
   logic [7:0]           byte_ff;
   logic                 out_valid_ff;
   hfdx_pkg::result_type res_ff;
   hfdx_pkg::result_type res_in;
   hfdx_pkg::state_type  state_ff;
   hfdx_pkg::state_type  state_in;
   logic [7:0]           timeout_ticks_ff;
   logic                 advance;
   logic                 step;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   hfdx_parser u_parser (
      .op            (op_ff),
      .rx_byte       (byte_ff),
      .timeout_ticks (timeout_ticks_ff),
      .cur           (state_ff),
      .nxt           (state_in),
      .res           (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         state_ff         <= '0;
         timeout_ticks_ff <= hfdx_pkg::TIMEOUT_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            timeout_ticks_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tuser;
         byte_ff <= req_tdata;
      end
      if (step) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_ff.body_position, res_ff.body_byte};
   assign rsp_tuser  = {res_ff.timed_out, res_ff.frame_bad, res_ff.frame_ok, res_ff.body_valid};

`ifndef ASSERT_OFF
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tuser))
      else $error("more than one response flag set");

   a_body_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[15:8] != 8'hFF))
      else $error("body position out of range");

   a_expire_hunt: assert property (@(posedge clock) disable iff (reset)
      (step && op_ff == hfdx_pkg::OP_TICK && state_ff.timeout_left == 8'd1)
      |=> (state_ff.phase == hfdx_pkg::PH_HUNT && res_ff.timed_out))
      else $error("timeout expiry did not return to hunt");
`endif

endmodule

### tb/sv/header_frame_deframer_xor_core_tb.sv
`timescale 1ns / 100ps
// Testbench for header_frame_deframer_xor_core: directed and random frames, noise and ticks.
// A scoreboard class predicts every response; needs hfdx_pkg and the core RTL only.
module header_frame_deframer_xor_core_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 160;

   class deframe_scoreboard;
      logic [7:0]           timeout_ticks;
      hfdx_pkg::phase_type  phase;
      logic [7:0]           running_xor;
      logic [7:0]           bytes_left;
      logic [7:0]           timeout_left;
      logic [7:0]           body_count;
      hfdx_pkg::result_type pending_q[$];
      int                   errors;

      function new();
         timeout_ticks = hfdx_pkg::TIMEOUT_RESET;
         phase         = hfdx_pkg::PH_HUNT;
         running_xor   = 8'h00;
         bytes_left    = 8'h00;
         timeout_left  = 8'h00;
         body_count    = 8'h00;
         errors        = 0;
      endfunction

      function void set_timeout(logic [7:0] value);
         timeout_ticks = value;
      endfunction

      function void hunt(logic [7:0] b);
         if (b == hfdx_pkg::HDR_U) begin
            phase        = hfdx_pkg::PH_N;
            timeout_left = timeout_ticks;
            running_xor  = b;
         end else begin
            phase = hfdx_pkg::PH_HUNT;
         end
      endfunction

      function void note_request(logic op, logic [7:0] b);
         hfdx_pkg::result_type want;
         logic [7:0]           header_byte;
         want = '0;
         if (op == hfdx_pkg::OP_TICK) begin
            if (timeout_left != 8'h00) begin
               timeout_left = timeout_left - 8'd1;
               if (timeout_left == 8'h00) begin
                  phase          = hfdx_pkg::PH_HUNT;
                  want.timed_out = 1'b1;
               end
            end
         end else begin
            case (phase)
               hfdx_pkg::PH_HUNT: begin
                  hunt(b);
               end
               hfdx_pkg::PH_N, hfdx_pkg::PH_E, hfdx_pkg::PH_R, hfdx_pkg::PH_TOKEN: begin
                  case (phase)
                     hfdx_pkg::PH_N: header_byte = hfdx_pkg::HDR_N;
                     hfdx_pkg::PH_E: header_byte = hfdx_pkg::HDR_E;
                     hfdx_pkg::PH_R: header_byte = hfdx_pkg::HDR_R;
                     default:        header_byte = hfdx_pkg::HDR_TOKEN;
                  endcase
                  if (b == header_byte) begin
                     running_xor = running_xor ^ b;
                     phase       = hfdx_pkg::phase_type'(phase + 3'd1);
                  end else begin
                     hunt(b);
                  end
               end
               hfdx_pkg::PH_LEN: begin
                  running_xor = running_xor ^ b;
                  bytes_left  = b;
                  body_count  = 8'h00;
                  phase       = hfdx_pkg::PH_TOKEN;
               end
               hfdx_pkg::PH_BODY: begin
                  bytes_left = bytes_left - 8'd1;
                  if (bytes_left != 8'h00) begin
                     running_xor        = running_xor ^ b;
                     want.body_valid    = 1'b1;
                     want.body_byte     = b;
                     want.body_position = body_count;
                     body_count         = body_count + 8'd1;
                  end else begin
                     phase = hfdx_pkg::PH_HUNT;
                     if (b == running_xor) want.frame_ok = 1'b1;
                     else want.frame_bad = 1'b1;
                  end
               end
               default: begin
                  phase = hfdx_pkg::PH_HUNT;
               end
            endcase
         end
         pending_q.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, seen);
         end
      endfunction

      function void check_response(logic [15:0] data, logic [3:0] user);
         hfdx_pkg::result_type want;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending, expected none actual 0x%0h/0x%0h",
                     $time, data, user);
            return;
         end
         want = pending_q.pop_front();
         compare_field("body_valid", want.body_valid, user[0]);
         compare_field("body_byte", want.body_byte, data[7:0]);
         compare_field("body_position", want.body_position, data[15:8]);
         compare_field("frame_ok", want.frame_ok, user[1]);
         compare_field("frame_bad", want.frame_bad, user[2]);
         compare_field("timed_out", want.timed_out, user[3]);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        req_tuser;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] body_byte, [15:8] body_position
   logic [3:0]  rsp_tuser;   // [0] body_valid, [1] frame_ok, [2] frame_bad, [3] timed_out
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;    // timeout_ticks

   deframe_scoreboard sb = new();
   bit jitter_on = 1'b1;
   int requests_sent = 0;
   int cycle_count = 0;

   header_frame_deframer_xor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("header_frame_deframer_xor_core_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      if (!reset && csr_valid && csr_ready) sb.set_timeout(csr_data);
   end

   always @(negedge clock) begin
      rsp_tready <= jitter_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
   end

   task automatic send_request(input logic op, input logic [7:0] b);
      while (jitter_on && $urandom_range(0, 99) < 26) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] value);
      wait_drained();
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // break_at flips one byte of the frame (header, length, body or checksum); -1 keeps it whole
   task automatic send_frame(input logic [7:0] len, input int break_at, input int tick_pct);
      logic [7:0] frame_q[$];
      logic [7:0] sum;
      int         body_len;
      body_len = (len == 8'd0) ? 255 : int'(len) - 1;
      frame_q.push_back(hfdx_pkg::HDR_U);
      frame_q.push_back(hfdx_pkg::HDR_N);
      frame_q.push_back(hfdx_pkg::HDR_E);
      frame_q.push_back(hfdx_pkg::HDR_R);
      frame_q.push_back(len);
      frame_q.push_back(hfdx_pkg::HDR_TOKEN);
      for (int i = 0; i < body_len; i++) frame_q.push_back(8'($urandom));
      sum = 8'h00;
      foreach (frame_q[i]) sum = sum ^ frame_q[i];
      frame_q.push_back(sum);
      if (break_at >= 0 && break_at < frame_q.size())
         frame_q[break_at] = frame_q[break_at] ^ 8'($urandom_range(1, 255));
      foreach (frame_q[i]) begin
         if ($urandom_range(0, 99) < tick_pct) send_request(hfdx_pkg::OP_TICK, 8'($urandom));
         send_request(hfdx_pkg::OP_BYTE, frame_q[i]);
      end
   endtask

   task automatic random_phase(input int target);
      int         kind;
      logic [7:0] len;
      while (requests_sent < target) begin
         kind = $urandom_range(0, 99);
         len  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(9, 40)) :
                                               8'($urandom_range(1, 8));
         if (kind < 60) begin
            send_frame(len, -1, 3);
         end else if (kind < 75) begin
            send_frame(len, $urandom_range(0, int'(len) + 5), 3);
         end else if (kind < 88) begin
            repeat ($urandom_range(1, 4))
               send_request(hfdx_pkg::OP_BYTE,
                            ($urandom_range(0, 3) == 0) ? hfdx_pkg::HDR_U : 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) send_request(hfdx_pkg::OP_TICK, 8'($urandom));
         end
      end
   endtask

   initial begin
      logic [7:0] timeout_plan[4];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = hfdx_pkg::OP_BYTE;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = 8'h00;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      send_request(hfdx_pkg::OP_TICK, 8'hFF);
      send_request(hfdx_pkg::OP_BYTE, 8'h00);
      send_frame(8'd2, -1, 0);
      repeat (5) send_request(hfdx_pkg::OP_TICK, 8'h00);
      send_request(hfdx_pkg::OP_BYTE, hfdx_pkg::HDR_U);
      send_request(hfdx_pkg::OP_BYTE, hfdx_pkg::HDR_N);
      send_frame(8'd1, 6, 0);

      write_timeout(8'd0);
      send_request(hfdx_pkg::OP_BYTE, hfdx_pkg::HDR_U);
      send_request(hfdx_pkg::OP_TICK, 8'hFF);

      timeout_plan = '{8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd20};
      for (int p = 0; p < 4; p++) begin
         write_timeout(timeout_plan[p]);
         jitter_on = (p != 2);
         if (p == 0) send_frame(8'd0, -1, 0);
         random_phase(requests_sent + PHASE_ITEMS);
      end
      jitter_on = 1'b1;

      wait_drained();
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("header_frame_deframer_xor_core_tb OK");
      end else begin
         $display("header_frame_deframer_xor_core_tb NOT OK");
      end
      $finish;
   end

endmodule
